>>> rtl/bsc_pkg.sv
// bsc_pkg: shared types, constants and helpers for the barometric compensation pipeline
// no dependencies
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int unsigned DivStages = 32;   // one quotient bit per stage

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } t_reg_idx;

    localparam logic [1:0]  OssReset  = 2'd3;
    localparam logic [31:0] Ofs4000   = 32'd4000;
    localparam logic [31:0] Ofs32768  = 32'd32768;
    localparam logic [31:0] K50000    = 32'd50000;
    localparam logic [31:0] K3038     = 32'd3038;
    localparam logic [31:0] K7357     = 32'd7357;
    localparam logic [31:0] K3791     = 32'd3791;

    // calibration set held in configuration
    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } t_cal;

    // sign-extend a half-word
    function automatic logic [31:0] sx16(input logic [15:0] h);
        sx16 = {{16{h[15]}}, h};
    endfunction

    // wrapping 32-bit product
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

    // arithmetic right shift
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = 32'($signed(x) >>> n);
    endfunction

endpackage

>>> rtl/baro_sensor_compensation.sv
// baro_sensor_compensation: stages a, temperature divider, b-f, pressure divider, g, h,
// output register; one transaction per cycle while not stalled (dividers fully pipelined).
// the whole pipeline advances when the output register is free or being taken.
// synchronous active-low reset clears valid bits and calibration (oversampling to 3).
// depends on bsc_pkg, bsc_regs, bsc_sdiv, bsc_udiv
`timescale 1ns / 1ps
module baro_sensor_compensation import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temp[15:0], raw_pressure[34:16], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // temperature_tenths[31:0], pressure_pa[63:32],
                                        // div_error[64], zero pad
);
    t_cal cal;
    logic en;

    bsc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cal(cal)
    );

    // calibration fields
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [1:0]  oss;
    always_comb begin
        ac1 = sx16(cal.ac1_ac2[31:16]); ac2 = sx16(cal.ac1_ac2[15:0]);
        ac3 = sx16(cal.ac3_ac4[31:16]); ac4 = {16'd0, cal.ac3_ac4[15:0]};
        ac5 = {16'd0, cal.ac5_ac6[31:16]}; ac6 = {16'd0, cal.ac5_ac6[15:0]};
        b1  = sx16(cal.b1_b2[31:16]);   b2  = sx16(cal.b1_b2[15:0]);
        mc  = sx16(cal.mc_md[31:16]);   md  = sx16(cal.mc_md[15:0]);
        oss = cal.oss;
    end

    // the output register takes a new item whenever it is empty or being read
    logic r_ov;
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // stage a: x1 and the temperature divisor
    logic        r_av;
    logic [31:0] r_ax1, r_aden;
    logic [18:0] r_aup;
    logic [31:0] n_ax1;
    assign n_ax1 = asr(mul32({16'd0, s_axis_tdata[15:0]} - ac6, ac5), 15);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_av <= 1'b0;
        else if (en)   r_av <= s_axis_tvalid;
        if (en) begin
            r_ax1  <= n_ax1;
            r_aden <= n_ax1 + md;
            r_aup  <= s_axis_tdata[34:16];
        end
    end

    // temperature division, carrying x1, up and a zero-divisor flag
    logic        tdv;
    logic [31:0] tq;
    logic [51:0] tside;
    bsc_sdiv #(.SideW(52)) u_tdiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_av),
        .i_num(mc << 11), .i_den(r_aden),
        .i_side({(r_aden == 32'd0), r_aup, r_ax1}),
        .o_valid(tdv), .o_quo(tq), .o_side(tside)
    );

    // stage b: b5, t, b6
    logic        r_bv, r_berr;
    logic [31:0] r_bt, r_bb6;
    logic [18:0] r_bup;
    logic [31:0] n_b5;
    assign n_b5 = tside[31:0] + tq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (en)  r_bv <= tdv;
        if (en) begin
            r_berr <= tside[51];
            r_bup  <= tside[50:32];
            r_bt   <= asr(n_b5 + 32'd8, 4);
            r_bb6  <= n_b5 - Ofs4000;
        end
    end

    // stage c: products on b6
    logic        r_cv, r_cerr;
    logic [31:0] r_ct, r_csq, r_cx2a, r_cx1b;
    logic [18:0] r_cup;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (en)  r_cv <= r_bv;
        if (en) begin
            r_cerr <= r_berr; r_ct <= r_bt; r_cup <= r_bup;
            r_csq  <= asr(mul32(r_bb6, r_bb6), 12);
            r_cx2a <= asr(mul32(ac2, r_bb6), 11);
            r_cx1b <= asr(mul32(ac3, r_bb6), 13);
        end
    end

    // stage d: products on sq
    logic        r_dv, r_derr;
    logic [31:0] r_dt, r_db3, r_dx3;
    logic [18:0] r_dup;
    logic [31:0] n_dx1a, n_dx2b, n_dx3a;
    always_comb begin
        n_dx1a = asr(mul32(b2, r_csq), 11);
        n_dx2b = asr(mul32(b1, r_csq), 16);
        n_dx3a = n_dx1a + r_cx2a;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (en)  r_dv <= r_cv;
        if (en) begin
            r_derr <= r_cerr; r_dt <= r_ct; r_dup <= r_cup;
            r_db3  <= asr(((ac1 * 32'd4 + n_dx3a) << oss) + 32'd2, 2);
            r_dx3  <= asr(r_cx1b + n_dx2b + 32'd2, 2);
        end
    end

    // stage e: b4 product, b7 difference
    logic        r_ev, r_eerr;
    logic [31:0] r_et, r_eb4, r_ediff;
    logic [31:0] n_eb4p;
    assign n_eb4p = mul32(ac4, r_dx3 + Ofs32768);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else if (en)  r_ev <= r_dv;
        if (en) begin
            r_et    <= r_dt;
            r_eb4   <= n_eb4p >> 15;
            r_eerr  <= r_derr;
            r_ediff <= {13'd0, r_dup} - r_db3;
        end
    end

    // stage f: b7 product and numerator choice
    logic        r_fv, r_ferr, r_fbig;
    logic [31:0] r_ft, r_fb4, r_fb7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (en)  r_fv <= r_ev;
        if (en) begin
            r_ft   <= r_et; r_fb4 <= r_eb4;
            r_ferr <= r_eerr || (r_eb4 == 32'd0);
            r_fb7  <= mul32(r_ediff, K50000 >> oss);
        end
    end
    assign r_fbig = r_fb7[31];

    // pressure division
    logic        pdv;
    logic [31:0] pq;
    logic [33:0] pside;
    bsc_udiv #(.SideW(34)) u_pdiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_fv),
        .i_num(r_fbig ? r_fb7 : (r_fb7 << 1)), .i_den(r_fb4),
        .i_side({r_ferr, r_fbig, r_ft}),
        .o_valid(pdv), .o_quo(pq), .o_side(pside)
    );

    // stage g: p and its shifted square term
    logic        r_gv, r_gerr;
    logic [31:0] r_gt, r_gp, r_gsq, r_gx2;
    logic [31:0] n_gp;
    assign n_gp = pside[32] ? (pq << 1) : pq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gv <= 1'b0;
        else if (en)  r_gv <= pdv;
        if (en) begin
            r_gerr <= pside[33]; r_gt <= pside[31:0]; r_gp <= n_gp;
            r_gsq  <= mul32(asr(n_gp, 8), asr(n_gp, 8));
            r_gx2  <= asr(32'd0 - mul32(K7357, n_gp), 16);
        end
    end

    // stage h: x1 scaling
    logic        r_hv, r_herr;
    logic [31:0] r_ht, r_hp, r_hx1, r_hx2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hv <= 1'b0;
        else if (en)  r_hv <= r_gv;
        if (en) begin
            r_herr <= r_gerr; r_ht <= r_gt; r_hp <= r_gp; r_hx2 <= r_gx2;
            r_hx1  <= asr(mul32(r_gsq, K3038), 16);
        end
    end

    // output register
    logic [31:0] r_ot, r_op;
    logic        r_oerr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= r_hv;
        if (en) begin
            r_oerr <= r_herr;
            r_ot   <= r_herr ? 32'd0 : r_ht;
            r_op   <= r_herr ? 32'd0 : (r_hp + asr(r_hx1 + r_hx2 + K3791, 4));
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_oerr, r_op, r_ot};
endmodule

>>> rtl/bsc_udiv.sv
// bsc_udiv: pipelined restoring unsigned 32-bit divider, one quotient bit per stage
// depends on bsc_pkg; side data of width SideW travels alongside
`timescale 1ns / 1ps
module bsc_udiv import bsc_pkg::*; #(
    parameter int unsigned SideW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_den,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [31:0]      o_quo,
    output logic [SideW-1:0] o_side
);
    logic [DivStages:0]             r_v;
    logic [DivStages:0][31:0]       r_rem;
    logic [DivStages:0][31:0]       r_num;
    logic [DivStages:0][31:0]       r_den;
    logic [DivStages:0][SideW-1:0]  r_side;

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_num[0]  = i_num;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    // one restoring step per stage; numerator shifts left taking quotient bits in
    for (genvar s = 0; s < DivStages; s++) begin : g_st
        logic [32:0] n_trial;
        logic [32:0] n_sh;
        always_comb begin
            n_sh    = {r_rem[s], r_num[s][31]};
            n_trial = n_sh - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_den[s+1]  <= r_den[s];
                if (!n_trial[32]) begin
                    r_rem[s+1] <= n_trial[31:0];
                    r_num[s+1] <= {r_num[s][30:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_sh[31:0];
                    r_num[s+1] <= {r_num[s][30:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[DivStages];
    assign o_quo   = r_num[DivStages];
    assign o_side  = r_side[DivStages];
endmodule

>>> rtl/bsc_regs.sv
// bsc_regs: configuration register file on the apb-style port
// depends on bsc_pkg
`timescale 1ns / 1ps
module bsc_regs import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cal        o_cal
);
    t_cal       r_cal;
    logic [2:0] n_idx;

    assign pready = 1'b1;
    assign n_idx  = paddr[4:2];

    // register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= {160'd0, OssReset};
        end else if (psel && penable && pwrite) begin
            unique case (n_idx)
                REG_AC1_AC2: r_cal.ac1_ac2 <= pwdata;
                REG_AC3_AC4: r_cal.ac3_ac4 <= pwdata;
                REG_AC5_AC6: r_cal.ac5_ac6 <= pwdata;
                REG_B1_B2:   r_cal.b1_b2   <= pwdata;
                REG_MC_MD:   r_cal.mc_md   <= pwdata;
                REG_OSS:     r_cal.oss     <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (n_idx)
            REG_AC1_AC2: prdata = r_cal.ac1_ac2;
            REG_AC3_AC4: prdata = r_cal.ac3_ac4;
            REG_AC5_AC6: prdata = r_cal.ac5_ac6;
            REG_B1_B2:   prdata = r_cal.b1_b2;
            REG_MC_MD:   prdata = r_cal.mc_md;
            REG_OSS:     prdata = {30'd0, r_cal.oss};
            default:     prdata = '0;
        endcase
    end

    assign o_cal = r_cal;
endmodule

>>> rtl/bsc_sdiv.sv
// bsc_sdiv: truncating signed 32-bit division built on the unsigned divider
// depends on bsc_pkg and bsc_udiv
`timescale 1ns / 1ps
module bsc_sdiv import bsc_pkg::*; #(
    parameter int unsigned SideW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_den,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [31:0]      o_quo,
    output logic [SideW-1:0] o_side
);
    logic [31:0]      n_an, n_ad, n_q;
    logic             n_neg;
    logic [SideW:0]   n_so;

    // magnitudes in, sign applied on the way out
    assign n_an  = i_num[31] ? (32'd0 - i_num) : i_num;
    assign n_ad  = i_den[31] ? (32'd0 - i_den) : i_den;
    assign n_neg = i_num[31] ^ i_den[31];

    bsc_udiv #(.SideW(SideW + 1)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_valid(i_valid),
        .i_num  (n_an),
        .i_den  (n_ad),
        .i_side ({n_neg, i_side}),
        .o_valid(o_valid),
        .o_quo  (n_q),
        .o_side (n_so)
    );

    assign o_quo  = n_so[SideW] ? (32'd0 - n_q) : n_q;
    assign o_side = n_so[SideW-1:0];
endmodule
